>>> src/wssh_pkg.sv
// weighted sampling sum heap: shared types and constants
// used by wssh_ctrl, wssh_datapath and weighted_sampling_sum_heap
`default_nettype none

package wssh_pkg;

  localparam int unsigned MASS_W   = 48;
  localparam int unsigned NODE_W   = 32;
  localparam int unsigned IMASS_W  = 32;
  localparam int unsigned DEG_W    = 24;
  localparam int unsigned FRAC_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PADDR_W  = 2;

  localparam logic [PADDR_W-1:0] ADDR_GROWTH_MODE = 2'd0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_INS_WR,
    CMD_ANC_RD,
    CMD_ANC_WR,
    CMD_MUL_LO,
    CMD_MUL_HI,
    CMD_DESC_RD,
    CMD_GO_LEFT,
    CMD_ADD_LEFT,
    CMD_NEXT_R,
    CMD_READ_ENT,
    CMD_GROW,
    CMD_COMMIT,
    CMD_SIFT_RDP,
    CMD_SIFT_RDO,
    CMD_SWAP,
    CMD_WR_G,
    CMD_RESULT
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    status_e res_code;
  } ctl_cmd_t;

  typedef struct packed {
    logic op;
    logic full;
    logic empty;
    logic ins_ovf;
    logic grow_ovf;
    logic idx_zero;
    logic go_left;
    logic found;
    logic r_valid;
    logic sift_up;
  } dp_flags_t;

endpackage

`default_nettype wire

>>> src/wssh_datapath.sv
// heap datapath: entry memories, index, cumulative mass, threshold and totals
// depends on wssh_pkg
`default_nettype none

module wssh_datapath
  import wssh_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctl_cmd_t            cmd_i,
  output dp_flags_t                flags_o,
  input  wire logic                growth_mode_i,
  input  wire logic                op_i,
  input  wire logic [NODE_W-1:0]   node_id_i,
  input  wire logic [IMASS_W-1:0]  initial_mass_i,
  input  wire logic [DEG_W-1:0]    degree_i,
  input  wire logic [FRAC_W-1:0]   sample_fraction_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [NODE_W-1:0]        chosen_node_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = CW + 1;

  logic [NODE_W-1:0]  node_mem [CAPACITY];
  logic [MASS_W-1:0]  mass_mem [CAPACITY];
  logic [MASS_W-1:0]  sub_mem  [CAPACITY];
  logic [DEG_W-1:0]   deg_mem  [CAPACITY];

  logic [NODE_W-1:0]  rd_node_q;
  logic [MASS_W-1:0]  rd_mass_q;
  logic [MASS_W-1:0]  rd_sub_q;
  logic [DEG_W-1:0]   rd_deg_q;

  logic [CW-1:0]      count_q, count_d;
  logic [MASS_W-1:0]  total_q, total_d;

  logic               op_q;
  logic [NODE_W-1:0]  in_node_q;
  logic [IMASS_W-1:0] in_mass_q;
  logic [DEG_W-1:0]   in_deg_q;
  logic [FRAC_W-1:0]  frac_q;
  logic [AW-1:0]      idx_q;
  logic [MASS_W-1:0]  cum_q;
  logic [63:0]        lo_q;
  logic [MASS_W-1:0]  th_q;
  logic [MASS_W-1:0]  delta_q;
  logic [NODE_W-1:0]  gnode_q;
  logic [MASS_W-1:0]  gmass_q;
  logic [MASS_W-1:0]  gsub_q;
  logic [DEG_W-1:0]   gdeg_q;
  logic [NODE_W-1:0]  pnode_q;
  logic [MASS_W-1:0]  pmass_q;
  logic [DEG_W-1:0]   pdeg_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [NODE_W-1:0]  res_node_q;

  logic [XW-1:0]      idx_x, count_x, l_x, r_x, other_x;
  logic [AW-1:0]      par;
  logic [MASS_W:0]    ins_sum, grow_sum, left_sum, mass_sum;
  logic [MASS_W-1:0]  osub, swap_sub;
  logic [MASS_W-1:0]  hi_prod;
  logic [AW-1:0]      sub_ra, ent_ra;
  logic               sub_re, ent_re, ent_we, sub_we;
  logic [NODE_W-1:0]  wd_node;
  logic [MASS_W-1:0]  wd_mass, wd_sub;
  logic [DEG_W-1:0]   wd_deg;

  assign idx_x   = XW'(idx_q);
  assign count_x = XW'(count_q);
  assign l_x     = (idx_x << 1) + XW'(1);
  assign r_x     = l_x + XW'(1);
  assign other_x = idx_q[0] ? idx_x + XW'(1) : idx_x - XW'(1);
  assign par     = AW'((idx_q - AW'(1)) >> 1);

  assign ins_sum  = {1'b0, total_q} + (MASS_W+1)'(in_mass_q);
  assign grow_sum = {1'b0, total_q} + {1'b0, delta_q};
  assign left_sum = {1'b0, cum_q} + {1'b0, rd_sub_q};
  assign mass_sum = {1'b0, cum_q} + {1'b0, rd_mass_q};
  assign osub     = (other_x < count_x) ? rd_sub_q : '0;
  assign swap_sub = gsub_q - gmass_q - osub;
  // 32 by 16 product of the fraction and the upper total bits
  assign hi_prod  = frac_q * total_q[MASS_W-1:32];

  always_comb begin
    flags_o.op       = op_q;
    flags_o.full     = (count_q == CW'(CAPACITY));
    flags_o.empty    = (count_q == '0);
    flags_o.ins_ovf  = ins_sum[MASS_W];
    flags_o.grow_ovf = grow_sum[MASS_W];
    flags_o.idx_zero = (idx_q == '0);
    flags_o.go_left  = (l_x < count_x) && ({1'b0, th_q} < left_sum);
    flags_o.found    = ({1'b0, th_q} < mass_sum);
    flags_o.r_valid  = (r_x < count_x);
    flags_o.sift_up  = (rd_mass_q < gmass_q);
  end

  // memory port steering
  always_comb begin
    sub_ra = idx_q;
    ent_ra = idx_q;
    sub_re = 1'b0;
    ent_re = 1'b0;
    ent_we = 1'b0;
    sub_we = 1'b0;
    wd_node = gnode_q;
    wd_mass = gmass_q;
    wd_deg  = gdeg_q;
    wd_sub  = gsub_q;
    case (cmd_i.cmd)
      CMD_DESC_RD: begin
        sub_ra = l_x[AW-1:0];
        sub_re = 1'b1;
        ent_re = 1'b1;
      end
      CMD_READ_ENT: begin
        sub_re = 1'b1;
        ent_re = 1'b1;
      end
      CMD_ANC_RD: begin
        sub_ra = par;
        sub_re = 1'b1;
      end
      CMD_SIFT_RDP: begin
        sub_ra = par;
        ent_ra = par;
        sub_re = 1'b1;
        ent_re = 1'b1;
      end
      CMD_SIFT_RDO: begin
        sub_ra = other_x[AW-1:0];
        sub_re = 1'b1;
      end
      CMD_INS_WR: begin
        ent_we  = 1'b1;
        sub_we  = 1'b1;
        wd_node = in_node_q;
        wd_mass = MASS_W'(in_mass_q);
        wd_deg  = in_deg_q;
        wd_sub  = MASS_W'(in_mass_q);
      end
      CMD_WR_G: begin
        ent_we = 1'b1;
        sub_we = 1'b1;
      end
      CMD_SWAP: begin
        ent_we  = 1'b1;
        sub_we  = 1'b1;
        wd_node = pnode_q;
        wd_mass = pmass_q;
        wd_deg  = pdeg_q;
        wd_sub  = swap_sub;
      end
      CMD_ANC_WR: begin
        sub_we = 1'b1;
        wd_sub = rd_sub_q + delta_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      node_mem[idx_q] <= wd_node;
      mass_mem[idx_q] <= wd_mass;
      deg_mem[idx_q]  <= wd_deg;
    end
    if (sub_we) begin
      sub_mem[idx_q] <= wd_sub;
    end
    if (ent_re) begin
      rd_node_q <= node_mem[ent_ra];
      rd_mass_q <= mass_mem[ent_ra];
      rd_deg_q  <= deg_mem[ent_ra];
    end
    if (sub_re) begin
      rd_sub_q <= sub_mem[sub_ra];
    end
  end

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    case (cmd_i.cmd)
      CMD_INS_WR: begin
        count_d = count_q + CW'(1);
        total_d = ins_sum[MASS_W-1:0];
      end
      CMD_COMMIT: total_d = grow_sum[MASS_W-1:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
    end else begin
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.cmd)
      CMD_LATCH: begin
        op_q      <= op_i;
        in_node_q <= node_id_i;
        in_mass_q <= initial_mass_i;
        in_deg_q  <= degree_i;
        frac_q    <= sample_fraction_i;
        idx_q     <= op_i ? '0 : count_q[AW-1:0];
        cum_q     <= '0;
      end
      CMD_INS_WR: delta_q <= MASS_W'(in_mass_q);
      CMD_ANC_RD: idx_q <= par;
      CMD_MUL_LO: lo_q <= frac_q * total_q[31:0];
      CMD_MUL_HI: th_q <= hi_prod + MASS_W'(lo_q[63:32]);
      CMD_GO_LEFT: idx_q <= l_x[AW-1:0];
      CMD_ADD_LEFT: begin
        if (l_x < count_x) begin
          cum_q <= left_sum[MASS_W-1:0];
        end
      end
      CMD_NEXT_R: begin
        cum_q <= mass_sum[MASS_W-1:0];
        idx_q <= r_x[AW-1:0];
      end
      CMD_READ_ENT: gmass_q <= rd_mass_q;
      CMD_GROW: begin
        gnode_q <= rd_node_q;
        gdeg_q  <= rd_deg_q;
        gsub_q  <= rd_sub_q;
        delta_q <= growth_mode_i ? MASS_W'({rd_deg_q, 1'b1}) : MASS_W'(1);
      end
      CMD_COMMIT: begin
        gmass_q <= gmass_q + delta_q;
        gsub_q  <= gsub_q + delta_q;
      end
      CMD_SIFT_RDO: begin
        pnode_q <= rd_node_q;
        pmass_q <= rd_mass_q;
        pdeg_q  <= rd_deg_q;
        gsub_q  <= rd_sub_q + delta_q;
      end
      CMD_SWAP: idx_q <= par;
      CMD_RESULT: begin
        res_status_q <= cmd_i.res_code;
        res_node_q   <= (cmd_i.res_code == ST_OK && op_q) ? gnode_q : '0;
      end
      default: begin
      end
    endcase
  end

  assign status_o      = res_status_q;
  assign chosen_node_o = res_node_q;

endmodule

`default_nettype wire

>>> src/wssh_ctrl.sv
// heap controller: sequences insert, descent, growth, sift-up, ancestor sum update and result word
// depends on wssh_pkg
`default_nettype none

module wssh_ctrl
  import wssh_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire dp_flags_t flags_i,
  output ctl_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL_HI,
    S_DESC_RD,
    S_DESC_L,
    S_DESC_M,
    S_GROW,
    S_GROW_CHK,
    S_SIFT_CHK,
    S_SIFT_CMP,
    S_SWAP,
    S_ANC_CHK,
    S_ANC_WR,
    S_RESP
  } state_e;

  state_e  state_q, state_d;
  status_e res_q, res_d;
  logic    out_valid_q, out_valid_d;
  logic    resp_go;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign resp_go     = !(out_valid_q && out_stall_i);

  always_comb begin
    state_d        = state_q;
    res_d          = res_q;
    cmd_o.cmd      = CMD_NONE;
    cmd_o.res_code = res_q;
    out_valid_d    = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cmd = CMD_LATCH;
          state_d   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!flags_i.op) begin
          if (flags_i.full) begin
            res_d   = ST_FULL;
            state_d = S_RESP;
          end else if (flags_i.ins_ovf) begin
            res_d   = ST_OVERFLOW;
            state_d = S_RESP;
          end else begin
            cmd_o.cmd = CMD_INS_WR;
            state_d   = S_ANC_CHK;
          end
        end else if (flags_i.empty) begin
          res_d   = ST_EMPTY;
          state_d = S_RESP;
        end else begin
          cmd_o.cmd = CMD_MUL_LO;
          state_d   = S_MUL_HI;
        end
      end
      S_MUL_HI: begin
        cmd_o.cmd = CMD_MUL_HI;
        state_d   = S_DESC_RD;
      end
      S_DESC_RD: begin
        cmd_o.cmd = CMD_DESC_RD;
        state_d   = S_DESC_L;
      end
      S_DESC_L: begin
        if (flags_i.go_left) begin
          cmd_o.cmd = CMD_GO_LEFT;
          state_d   = S_DESC_RD;
        end else begin
          cmd_o.cmd = CMD_ADD_LEFT;
          state_d   = S_DESC_M;
        end
      end
      S_DESC_M: begin
        if (flags_i.found) begin
          cmd_o.cmd = CMD_READ_ENT;
          state_d   = S_GROW;
        end else if (flags_i.r_valid) begin
          cmd_o.cmd = CMD_NEXT_R;
          state_d   = S_DESC_RD;
        end else begin
          res_d   = ST_NOT_FOUND;
          state_d = S_RESP;
        end
      end
      S_GROW: begin
        cmd_o.cmd = CMD_GROW;
        state_d   = S_GROW_CHK;
      end
      S_GROW_CHK: begin
        if (flags_i.grow_ovf) begin
          res_d   = ST_OVERFLOW;
          state_d = S_RESP;
        end else begin
          cmd_o.cmd = CMD_COMMIT;
          state_d   = S_SIFT_CHK;
        end
      end
      S_SIFT_CHK: begin
        if (flags_i.idx_zero) begin
          cmd_o.cmd = CMD_WR_G;
          state_d   = S_ANC_CHK;
        end else begin
          cmd_o.cmd = CMD_SIFT_RDP;
          state_d   = S_SIFT_CMP;
        end
      end
      S_SIFT_CMP: begin
        if (flags_i.sift_up) begin
          cmd_o.cmd = CMD_SIFT_RDO;
          state_d   = S_SWAP;
        end else begin
          cmd_o.cmd = CMD_WR_G;
          state_d   = S_ANC_CHK;
        end
      end
      S_SWAP: begin
        cmd_o.cmd = CMD_SWAP;
        state_d   = S_SIFT_CHK;
      end
      S_ANC_CHK: begin
        if (flags_i.idx_zero) begin
          res_d   = ST_OK;
          state_d = S_RESP;
        end else begin
          cmd_o.cmd = CMD_ANC_RD;
          state_d   = S_ANC_WR;
        end
      end
      S_ANC_WR: begin
        cmd_o.cmd = CMD_ANC_WR;
        state_d   = S_ANC_CHK;
      end
      S_RESP: begin
        if (resp_go) begin
          cmd_o.cmd   = CMD_RESULT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_no_load_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> (cmd_o.cmd != CMD_RESULT))
    else $error("result word overwritten while held");

  a_valid_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RESP))
    else $error("result raised outside response state");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_DISPATCH))
    else $error("accepted word not dispatched");
`endif

endmodule

`default_nettype wire

>>> src/weighted_sampling_sum_heap.sv
// weighted sampling sum heap top level: config register, controller, datapath
// depends on wssh_pkg, wssh_ctrl, wssh_datapath
//
// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o  op, node_id, initial_mass, degree, sample_fraction
// out      output     out_valid_o / out_stall_i status, chosen_node
// cfg      input      apb psel/penable/pwrite  growth_mode at address 0
//
// one word at a time; an insert and a sample both walk the tree level by level,
// their pace bounded by the single-port entry memories read once per tree level
// reset empties the heap and clears the total at once; no clearing pass
// a new word is taken while a finished result still waits under out_stall_i
`default_nettype none

module weighted_sampling_sum_heap
  import wssh_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                op_i,
  input  wire logic [NODE_W-1:0]   node_id_i,
  input  wire logic [IMASS_W-1:0]  initial_mass_i,
  input  wire logic [DEG_W-1:0]    degree_i,
  input  wire logic [FRAC_W-1:0]   sample_fraction_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [NODE_W-1:0]        chosen_node_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic      growth_mode_q;
  ctl_cmd_t  cmd;
  dp_flags_t flags;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_GROWTH_MODE) ? {31'b0, growth_mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      growth_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == ADDR_GROWTH_MODE) begin
      growth_mode_q <= pwdata[0];
    end
  end

  wssh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  wssh_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .flags_o           (flags),
    .growth_mode_i     (growth_mode_q),
    .op_i              (op_i),
    .node_id_i         (node_id_i),
    .initial_mass_i    (initial_mass_i),
    .degree_i          (degree_i),
    .sample_fraction_i (sample_fraction_i),
    .status_o          (status_o),
    .chosen_node_o     (chosen_node_o)
  );

endmodule

`default_nettype wire

>>> tb/weighted_sampling_sum_heap_tb.sv
// testbench for weighted_sampling_sum_heap: random inserts and samples checked against
// a heap predictor held in a small scoreboard class; depends on wssh_pkg and the rtl
`default_nettype none

module weighted_sampling_sum_heap_tb;
  import wssh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_CAP = 1024;
  localparam int unsigned SETTLE   = 200;
  localparam logic [47:0] MASS_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    status_e     st;
    logic [31:0] node;
  } result_t;

  class heap_scoreboard;
    logic [31:0] node_q[HEAP_CAP];
    logic [47:0] mass_q[HEAP_CAP];
    logic [47:0] sub_q[HEAP_CAP];
    logic [23:0] deg_q[HEAP_CAP];
    int unsigned count;
    logic [47:0] total = '0;
    logic        mode;
    result_t     expected_q[$];
    int          errors;

    function bit below(logic [31:0] u, logic [63:0] cum);
      logic [79:0] prod;
      prod = {48'd0, u} * {32'd0, total};
      return {16'd0, prod[79:32]} < cum;
    endfunction

    // grown entry at c moves into parent p; parent sum already includes the growth
    function void swap_up(int unsigned c, int unsigned p);
      int unsigned other;
      logic [47:0] other_sub;
      logic [31:0] tn;
      logic [47:0] tm;
      logic [23:0] td;
      other = (c == 2 * p + 1) ? 2 * p + 2 : 2 * p + 1;
      other_sub = (other < count) ? sub_q[other] : 48'd0;
      tn = node_q[c];
      tm = mass_q[c];
      td = deg_q[c];
      node_q[c] = node_q[p];
      mass_q[c] = mass_q[p];
      deg_q[c] = deg_q[p];
      node_q[p] = tn;
      mass_q[p] = tm;
      deg_q[p] = td;
      sub_q[c] = sub_q[p] - tm - other_sub;
    endfunction

    function result_t insert_word(logic [31:0] id, logic [31:0] m, logic [23:0] d);
      result_t res;
      int unsigned i;
      res = '{st: ST_OK, node: 32'd0};
      if (count >= HEAP_CAP) begin
        res.st = ST_FULL;
      end else if ({16'd0, total} + {32'd0, m} > {16'd0, MASS_MAX}) begin
        res.st = ST_OVERFLOW;
      end else begin
        i = count;
        node_q[i] = id;
        mass_q[i] = {16'd0, m};
        sub_q[i] = {16'd0, m};
        deg_q[i] = d;
        while (i > 0) begin
          i = (i - 1) / 2;
          sub_q[i] = sub_q[i] + {16'd0, m};
        end
        count++;
        total = total + {16'd0, m};
      end
      return res;
    endfunction

    function result_t sample_word(logic [31:0] u);
      result_t res;
      int unsigned i, l, r, p;
      logic [63:0] cum;
      logic [47:0] delta;
      bit hit;
      res = '{st: ST_OK, node: 32'd0};
      if (count == 0) begin
        res.st = ST_EMPTY;
        return res;
      end
      i = 0;
      cum = 0;
      hit = 0;
      forever begin
        l = 2 * i + 1;
        r = 2 * i + 2;
        if (l < count) begin
          if (below(u, cum + sub_q[l])) begin
            i = l;
            continue;
          end
          cum += sub_q[l];
        end
        cum += mass_q[i];
        if (below(u, cum)) begin
          hit = 1;
          break;
        end
        if (r < count) begin
          i = r;
          continue;
        end
        break;
      end
      if (!hit) begin
        res.st = ST_NOT_FOUND;
        return res;
      end
      delta = mode ? 2 * {24'd0, deg_q[i]} + 48'd1 : 48'd1;
      if ({16'd0, total} + {16'd0, delta} > {16'd0, MASS_MAX}) begin
        res.st = ST_OVERFLOW;
        return res;
      end
      res.node = node_q[i];
      mass_q[i] += delta;
      sub_q[i] += delta;
      while (i > 0 && mass_q[(i - 1) / 2] < mass_q[i]) begin
        p = (i - 1) / 2;
        sub_q[p] += delta;
        swap_up(i, p);
        i = p;
      end
      while (i > 0) begin
        i = (i - 1) / 2;
        sub_q[i] += delta;
      end
      total += delta;
      return res;
    endfunction

    function void note_word(logic op, logic [31:0] id, logic [31:0] m, logic [23:0] d,
                            logic [31:0] u);
      if (op) expected_q.push_back(sample_word(u));
      else expected_q.push_back(insert_word(id, m, d));
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] node);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("word out with nothing expected: status %0d chosen_node %0h", st, node);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (st !== exp_r.st) begin
        $error("status: expected %0d, got %0d", exp_r.st, st);
        errors++;
      end
      if (node !== exp_r.node) begin
        $error("chosen_node: expected %0h, got %0h", exp_r.node, node);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              op = 1'b0;
  logic [31:0]       node_id = '0;
  logic [31:0]       initial_mass = '0;
  logic [23:0]       degree = '0;
  logic [31:0]       sample_fraction = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        status;
  logic [31:0]       chosen_node;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  heap_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic out_take = 1'b0;

  weighted_sampling_sum_heap #(.CAPACITY(HEAP_CAP)) i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .node_id_i(node_id), .initial_mass_i(initial_mass),
    .degree_i(degree), .sample_fraction_i(sample_fraction),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .chosen_node_o(chosen_node),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // outputs are settled at the falling edge, so the take is decided there
  always @(negedge clk) out_take <= out_valid && !out_stall;

  always @(posedge clk) begin
    if (rst_n && out_take) sb.check_result(status, chosen_node);
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  // called at a rising edge; leaves the caller at the edge where the word went in
  task automatic send_word(logic o, logic [31:0] id, logic [31:0] m, logic [23:0] d,
                           logic [31:0] u);
    logic stalled;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    op <= o;
    node_id <= id;
    initial_mass <= m;
    degree <= d;
    sample_fraction <= u;
    forever begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
    end
    sb.note_word(o, id, m, d, u);
  endtask

  task automatic random_word(int unsigned insert_pct);
    logic [31:0] m;
    logic [23:0] d;
    case ($urandom_range(0, 7))
      0: m = 32'd0;
      1: m = $urandom();
      default: m = $urandom_range(1, 64);
    endcase
    d = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 10));
    send_word($urandom_range(0, 99) >= insert_pct, $urandom(), m, d, $urandom());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(logic v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_GROWTH_MODE;
    pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.mode = v;
  endtask

  task automatic random_phase(int unsigned n, int unsigned idle, int unsigned stall,
                              int unsigned insert_pct);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) random_word(insert_pct);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mode(1'b0);

    // empty heap, zero-mass only heap, then field extremes
    send_word(1'b1, 32'h0, 32'h0, 24'h0, 32'h0);
    send_word(1'b0, 32'h0, 32'h0, 24'h0, 32'h0);
    send_word(1'b1, '1, '1, '1, '1);
    send_word(1'b1, 32'h0, 32'h0, 24'h0, 32'h0);
    send_word(1'b0, '1, '1, '1, 32'h0);
    send_word(1'b0, 32'h1234_5678, 32'd1, '1, 32'h0);
    send_word(1'b0, 32'hA5A5_A5A5, 32'd2, 24'd3, 32'h0);
    send_word(1'b1, 32'h0, 32'h0, 24'h0, 32'h0);
    send_word(1'b1, 32'h0, 32'h0, 24'h0, '1);
    send_word(1'b1, 32'h0, 32'h0, 24'h0, 32'h8000_0000);
    drain();
    write_mode(1'b1);
    // degree-based growth (2*degree+1) pushes a small leaf past its parent
    send_word(1'b1, 32'h0, 32'h0, 24'h0, '1);
    send_word(1'b1, 32'h0, 32'h0, 24'h0, 32'hFFFF_FF00);
    send_word(1'b1, 32'h0, 32'h0, 24'h0, 32'h0);

    random_phase(500, 0, 0, 50);
    drain();
    write_mode(1'b0);
    random_phase(500, 49, 0, 50);
    // sender holds off until everything is back
    drain();
    random_phase(500, 0, 49, 50);
    drain();
    write_mode(1'b1);
    random_phase(500, 12, 12, 50);
    drain();
    write_mode(1'b0);

    // fill to capacity, then inserts into a full heap and samples
    send_idle_pct = 0;
    stall_pct = 0;
    while (sb.count < HEAP_CAP) random_word(100);
    repeat (3) random_word(100);
    random_phase(20, 12, 12, 20);
    drain();

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
src/wssh_pkg.sv
src/wssh_datapath.sv
src/wssh_ctrl.sv
src/weighted_sampling_sum_heap.sv
tb/weighted_sampling_sum_heap_tb.sv
